// ===== src/audio_staging_fifo_upsampler_top_macros.svh =====
// Assertion helpers for the block's top-level file.
`ifndef AUDIO_STAGING_FIFO_UPSAMPLER_TOP_MACROS_SVH
`define AUDIO_STAGING_FIFO_UPSAMPLER_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define AFU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define AFU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/afu_pkg.sv =====
package afu_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int CFG_W         = 9;
   localparam int SAMPLE_W      = 16;
   localparam int FILL_W        = 9;
   localparam int TOTAL_W       = 32;
   localparam logic [CFG_W-1:0] PREBUF_RESET = 9'd128;

   typedef enum logic [2:0] {
      CMD_PUSH  = 3'd0,
      CMD_PULL  = 3'd1,
      CMD_DRAIN = 3'd2,
      CMD_START = 3'd3,
      CMD_STOP  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_INACTIVE  = 2'd0,
      MODE_PREBUFFER = 2'd1,
      MODE_ACTIVE    = 2'd2,
      MODE_DRAINING  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_REFUSED = 2'd1,
      STAT_DROPPED = 2'd2
   } status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_PULL = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic [2:0]                 command;
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
      logic                       last_of_call;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       last;
      logic [1:0]                 status;
      logic                       audio_valid;
      logic [1:0]                 mode;
      logic [FILL_W-1:0]          fill_level;
      logic [TOTAL_W-1:0]         underrun_count;
      logic [TOTAL_W-1:0]         overflow_count;
      logic [TOTAL_W-1:0]         frames_in;
      logic [TOTAL_W-1:0]         frames_out;
   } rsp_type;

   // Enqueue request into the result queue: one result, or a pair.
   typedef struct packed {
      logic valid;
      logic pair;
   } wr_type;

endpackage

// ===== src/afu_ram.sv =====
module afu_ram #(
   parameter int DEPTH = afu_pkg::DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/afu_out.sv =====
module afu_out (
   input  logic             clock,
   input  logic             reset,
   input  afu_pkg::wr_type  wr,
   input  afu_pkg::rsp_type data0,
   input  afu_pkg::rsp_type data1,
   output logic             room,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output afu_pkg::rsp_type rsp_data
);

   afu_pkg::rsp_type q_ff [4];
   logic [1:0] head_ff, head_in;
   logic [1:0] tail_ff, tail_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] n_wr;
   logic       pop;

   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_data  = q_ff[head_ff];
   assign pop       = rsp_valid && rsp_ready;
   // a new item is taken only when a full pair still fits
   assign room      = (cnt_ff <= 3'd2);

   always_comb begin
      n_wr = 3'd0;
      if (wr.valid) begin
         n_wr = wr.pair ? 3'd2 : 3'd1;
      end
      cnt_in  = cnt_ff + n_wr - {2'd0, pop};
      tail_in = tail_ff + n_wr[1:0];
      head_in = pop ? head_ff + 2'd1 : head_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.valid) begin
         q_ff[tail_ff] <= data0;
         if (wr.pair) begin
            q_ff[tail_ff + 2'd1] <= data1;
         end
      end
   end

endmodule

// ===== src/afu_ctl.sv =====
module afu_ctl #(
   parameter int DEPTH = afu_pkg::DEPTH_DEFAULT,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  afu_pkg::req_type            req_data,
   input  logic                        csr_write_enable,
   input  logic [afu_pkg::CFG_W-1:0]   csr_write_data,
   input  logic                        out_room,
   output afu_pkg::wr_type             out_wr,
   output afu_pkg::rsp_type            out_data0,
   output afu_pkg::rsp_type            out_data1,
   output logic                        ram_wr_en,
   output logic [AW-1:0]               ram_wr_addr,
   output logic [31:0]                 ram_wr_data,
   output logic                        ram_rd_en,
   output logic [AW-1:0]               ram_rd_addr,
   input  logic [31:0]                 ram_rd_data
);

   localparam int CMP_W = (CW > afu_pkg::CFG_W) ? CW : afu_pkg::CFG_W;
   localparam int SW    = afu_pkg::SAMPLE_W;
   localparam int TW    = afu_pkg::TOTAL_W;

   afu_pkg::ctl_state_type state_ff, state_in;
   afu_pkg::mode_type      mode_ff, mode_in;
   logic [AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   alloc_ff, alloc_in;
   logic signed [SW-1:0]   prev_l_ff, prev_l_in;
   logic signed [SW-1:0]   prev_r_ff, prev_r_in;
   logic [TW-1:0]          underrun_ff, underrun_in;
   logic [TW-1:0]          overflow_ff, overflow_in;
   logic [TW-1:0]          in_total_ff, in_total_in;
   logic [TW-1:0]          out_total_ff, out_total_in;
   logic                   short_ff, short_in;
   logic                   drop_ff, drop_in;
   logic [afu_pkg::CFG_W-1:0] prebuf_ff;
   logic                   eol_ff, eol_in;

   logic                   accept;
   logic                   eol;
   logic                   full;
   logic                   drop_now;
   logic                   pop;
   logic                   silent;
   afu_pkg::status_type    res_status;
   logic                   res_valid;
   logic signed [SW-1:0]   cur_l, cur_r;
   logic signed [SW-1:0]   mid_l, mid_r;
   logic [SW:0]            sum_l, sum_r, adj_l, adj_r;
   logic [SW-1:0]          out_l0, out_r0, out_l1, out_r1;

   assign req_ready = (state_ff == afu_pkg::CTL_IDLE) && out_room;
   assign accept    = req_valid && req_ready;
   assign eol       = req_data.last_of_call;
   assign full      = (count_ff == CW'(DEPTH));

   // midpoint of previous and current frame, truncated toward zero
   assign cur_l = ram_rd_data[SW-1:0];
   assign cur_r = ram_rd_data[2*SW-1:SW];
   assign sum_l = {prev_l_ff[SW-1], prev_l_ff} + {cur_l[SW-1], cur_l};
   assign sum_r = {prev_r_ff[SW-1], prev_r_ff} + {cur_r[SW-1], cur_r};
   assign adj_l = sum_l + {{SW{1'b0}}, sum_l[SW]};
   assign adj_r = sum_r + {{SW{1'b0}}, sum_r[SW]};
   assign mid_l = adj_l[SW:1];
   assign mid_r = adj_r[SW:1];

   assign pop = !short_ff && (count_ff != '0);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      count_in     = count_ff;
      alloc_in     = alloc_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      underrun_in  = underrun_ff;
      overflow_in  = overflow_ff;
      in_total_in  = in_total_ff;
      out_total_in = out_total_ff;
      short_in     = short_ff;
      drop_in      = drop_ff;
      eol_in       = eol_ff;
      drop_now     = drop_ff;
      silent       = 1'b0;
      res_status   = afu_pkg::STAT_OK;
      res_valid    = 1'b0;
      out_wr       = '0;
      out_l0       = '0;
      out_r0       = '0;
      out_l1       = '0;
      out_r1       = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_ptr_ff;
      ram_wr_data  = {req_data.right_in, req_data.left_in};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_ptr_ff;

      case (state_ff)
         afu_pkg::CTL_IDLE: begin
            if (accept) begin
               out_wr.valid = 1'b1;
               case (req_data.command)
                  afu_pkg::CMD_PUSH: begin
                     if (mode_ff == afu_pkg::MODE_INACTIVE || !alloc_ff) begin
                        res_status = afu_pkg::STAT_REFUSED;
                        if (eol) begin
                           drop_in = 1'b0;
                        end
                     end else begin
                        if (full) begin
                           res_status = afu_pkg::STAT_DROPPED;
                           drop_now   = 1'b1;
                           drop_in    = 1'b1;
                        end else begin
                           ram_wr_en   = 1'b1;
                           wr_ptr_in   = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0
                                                                       : wr_ptr_ff + AW'(1);
                           count_in    = count_ff + CW'(1);
                           in_total_in = in_total_ff + TW'(1);
                        end
                        if (eol) begin
                           if (drop_now) begin
                              overflow_in = overflow_ff + TW'(1);
                           end
                           drop_in = 1'b0;
                           if (mode_ff == afu_pkg::MODE_PREBUFFER &&
                               CMP_W'(count_in) >= CMP_W'(prebuf_ff)) begin
                              mode_in = afu_pkg::MODE_ACTIVE;
                           end
                        end
                     end
                  end
                  afu_pkg::CMD_PULL: begin
                     if (mode_ff != afu_pkg::MODE_ACTIVE &&
                         mode_ff != afu_pkg::MODE_DRAINING) begin
                        res_status = afu_pkg::STAT_REFUSED;
                        if (eol) begin
                           short_in = 1'b0;
                        end
                     end else begin
                        // frame comes back from the store next cycle
                        out_wr.valid = 1'b0;
                        ram_rd_en    = 1'b1;
                        eol_in       = eol;
                        state_in     = afu_pkg::CTL_PULL;
                     end
                  end
                  afu_pkg::CMD_DRAIN: begin
                     if (mode_ff == afu_pkg::MODE_ACTIVE ||
                         mode_ff == afu_pkg::MODE_PREBUFFER) begin
                        mode_in = afu_pkg::MODE_DRAINING;
                     end else begin
                        res_status = afu_pkg::STAT_REFUSED;
                     end
                  end
                  afu_pkg::CMD_START: begin
                     if (mode_ff != afu_pkg::MODE_INACTIVE || alloc_ff) begin
                        res_status = afu_pkg::STAT_REFUSED;
                     end else begin
                        alloc_in     = 1'b1;
                        rd_ptr_in    = '0;
                        wr_ptr_in    = '0;
                        count_in     = '0;
                        prev_l_in    = '0;
                        prev_r_in    = '0;
                        underrun_in  = '0;
                        overflow_in  = '0;
                        in_total_in  = '0;
                        out_total_in = '0;
                        short_in     = 1'b0;
                        drop_in      = 1'b0;
                        mode_in      = afu_pkg::MODE_PREBUFFER;
                     end
                  end
                  afu_pkg::CMD_STOP: begin
                     mode_in   = afu_pkg::MODE_INACTIVE;
                     alloc_in  = 1'b0;
                     rd_ptr_in = '0;
                     wr_ptr_in = '0;
                     count_in  = '0;
                     short_in  = 1'b0;
                     drop_in   = 1'b0;
                  end
                  default: begin
                     res_status = afu_pkg::STAT_REFUSED;
                  end
               endcase
            end
         end
         afu_pkg::CTL_PULL: begin
            out_wr.valid = 1'b1;
            out_wr.pair  = 1'b1;
            if (pop) begin
               rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
               count_in  = count_ff - CW'(1);
               prev_l_in = cur_l;
               prev_r_in = cur_r;
               res_valid = 1'b1;
               out_l0    = mid_l;
               out_r0    = mid_r;
               out_l1    = cur_l;
               out_r1    = cur_r;
            end else begin
               silent   = 1'b1;
               short_in = 1'b1;
            end
            out_total_in = out_total_ff + TW'(2);
            if (eol_ff) begin
               if (silent) begin
                  if (mode_ff == afu_pkg::MODE_DRAINING) begin
                     mode_in = afu_pkg::MODE_INACTIVE;
                  end else begin
                     underrun_in = underrun_ff + TW'(1);
                  end
               end
               short_in = 1'b0;
            end
            state_in = afu_pkg::CTL_IDLE;
         end
         default: begin
            state_in = afu_pkg::CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      out_data0.left_out       = out_l0;
      out_data0.right_out      = out_r0;
      out_data0.last           = !out_wr.pair;
      out_data0.status         = res_status;
      out_data0.audio_valid    = res_valid;
      out_data0.mode           = mode_in;
      out_data0.fill_level     = afu_pkg::FILL_W'(count_in);
      out_data0.underrun_count = underrun_in;
      out_data0.overflow_count = overflow_in;
      out_data0.frames_in      = in_total_in;
      out_data0.frames_out     = out_total_in;
      out_data1                = out_data0;
      out_data1.left_out       = out_l1;
      out_data1.right_out      = out_r1;
      out_data1.last           = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= afu_pkg::CTL_IDLE;
         mode_ff      <= afu_pkg::MODE_INACTIVE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         alloc_ff     <= 1'b0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         underrun_ff  <= '0;
         overflow_ff  <= '0;
         in_total_ff  <= '0;
         out_total_ff <= '0;
         short_ff     <= 1'b0;
         drop_ff      <= 1'b0;
         prebuf_ff    <= afu_pkg::PREBUF_RESET;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         alloc_ff     <= alloc_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         underrun_ff  <= underrun_in;
         overflow_ff  <= overflow_in;
         in_total_ff  <= in_total_in;
         out_total_ff <= out_total_in;
         short_ff     <= short_in;
         drop_ff      <= drop_in;
         if (csr_write_enable) begin
            prebuf_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      eol_ff <= eol_in;
   end

endmodule

// ===== src/audio_staging_fifo_upsampler_top.sv =====
// Stereo frame FIFO with 2x linear-interpolation upsampling. Frames live in a
// DEPTH-entry single-port-style RAM with a registered read. Push, drain, start,
// stop and refused items finish in their transfer cycle; an accepted pull also
// passes the PULL state: the stored frame comes back the cycle after the
// transfer, and the midpoint, pointer and counter updates happen then. Each
// accepted pull yields two results (midpoint, then current frame), other items
// one. Results go through a four-entry queue and show up the cycle after they
// are produced; a new item is taken while results still wait, as long as two
// queue slots are free. The store needs no clearing after reset (entries are
// only read once written). The user writes prebuffer_level via csr_write_enable
// and csr_write_data only while idle; the block itself does not enforce this.
`include "audio_staging_fifo_upsampler_top_macros.svh"

module audio_staging_fifo_upsampler_top #(
   parameter int DEPTH = afu_pkg::DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  afu_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output afu_pkg::rsp_type          rsp_data,
   input  logic                      csr_write_enable,
   input  logic [afu_pkg::CFG_W-1:0] csr_write_data
);

   localparam int AW = $clog2(DEPTH);

   afu_pkg::wr_type  out_wr;
   afu_pkg::rsp_type out_data0;
   afu_pkg::rsp_type out_data1;
   logic             out_room;
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [31:0]      ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [31:0]      ram_rd_data;

   afu_ctl #(.DEPTH(DEPTH)) u_ctl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .out_room         (out_room),
      .out_wr           (out_wr),
      .out_data0        (out_data0),
      .out_data1        (out_data1),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data)
   );

   afu_ram #(.DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   afu_out u_out (
      .clock     (clock),
      .reset     (reset),
      .wr        (out_wr),
      .data0     (out_data0),
      .data1     (out_data1),
      .room      (out_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `AFU_ASSERT_NOW(a_no_rw_same_cycle, clock, reset, ram_wr_en, !ram_rd_en,
                   "store read and write in one cycle")
   `AFU_ASSERT_NEXT(a_pull_interlock, clock, reset, ram_rd_en, !req_ready,
                    "item taken while a pull waits on the store")
   `AFU_ASSERT_NEXT(a_pair_follows_read, clock, reset, ram_rd_en,
                    out_wr.valid && out_wr.pair, "pull without its result pair")
   `AFU_ASSERT_NEXT(a_pair_second_kept, clock, reset, rsp_valid && !rsp_data.last,
                    rsp_valid, "second frame of a pair lost")

endmodule

// ===== sim/tb_audio_staging_fifo_upsampler_top.sv =====
`timescale 1ns / 100ps

module tb_audio_staging_fifo_upsampler_top;
   import afu_pkg::*;

   localparam int FIFO_DEPTH      = DEPTH_DEFAULT;
   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 9;
   localparam int MAX_IDLE        = 18;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 20;
   localparam int ITEMS_PER_PHASE = 170;
   localparam int NUM_PHASES      = 7;
   localparam int MAX_REPORTS     = 40;
   localparam longint LIMIT_CYCLES = 1_500_000;
   localparam logic [2:0] CMD_SPARE = 3'd7;

   typedef struct {
      req_type    item;
      bit         typed;
      status_type want_status;
      mode_type   want_mode;
   } step_row;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [CFG_W-1:0]  csr_write_data = '0;

   // shadow of the block's state
   logic signed [SAMPLE_W-1:0] store_l [FIFO_DEPTH];
   logic signed [SAMPLE_W-1:0] store_r [FIFO_DEPTH];
   logic [7:0]          rd_idx;
   logic [7:0]          wr_idx;
   logic [FILL_W-1:0]   held;
   mode_type            cur_mode;
   bit                  store_live;
   logic signed [SAMPLE_W-1:0] prev_l;
   logic signed [SAMPLE_W-1:0] prev_r;
   logic [TOTAL_W-1:0]  total_under;
   logic [TOTAL_W-1:0]  total_over;
   logic [TOTAL_W-1:0]  total_in;
   logic [TOTAL_W-1:0]  total_out;
   bit                  short_seen;
   bit                  drop_seen;
   logic [CFG_W-1:0]    prebuf_level;

   rsp_type owed_frames[$];
   int      mismatches = 0;
   int      effective = 0;
   bit      tx_quiet = 1'b0;
   bit      rx_quiet = 1'b0;

   audio_staging_fifo_upsampler_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   function automatic rsp_type make_rsp(input logic signed [SAMPLE_W-1:0] l,
                                        input logic signed [SAMPLE_W-1:0] r,
                                        input logic fin, input logic [1:0] st,
                                        input logic audio);
      rsp_type o;
      o.left_out       = l;
      o.right_out      = r;
      o.last           = fin;
      o.status         = st;
      o.audio_valid    = audio;
      o.mode           = cur_mode;
      o.fill_level     = held;
      o.underrun_count = total_under;
      o.overflow_count = total_over;
      o.frames_in      = total_in;
      o.frames_out     = total_out;
      return o;
   endfunction

   function automatic rsp_type plain_rsp(input status_type st, input mode_type md);
      rsp_type o;
      o        = '0;
      o.last   = 1'b1;
      o.status = st;
      o.mode   = md;
      return o;
   endfunction

   // Steps the shadow FIFO by one item and queues the frames it owes.
   function automatic void advance_fifo(input req_type it);
      logic signed [SAMPLE_W-1:0] cl, cr;
      int ml, mr;
      logic [1:0] st;
      bit audio;
      cl = '0;
      cr = '0;
      ml = 0;
      mr = 0;
      st = STAT_OK;
      audio = 1'b0;
      case (it.command)
         CMD_PUSH: begin
            if (cur_mode == MODE_INACTIVE || !store_live) begin
               st = STAT_REFUSED;
               if (it.last_of_call) drop_seen = 1'b0;
            end else begin
               if (held >= FIFO_DEPTH) begin
                  st = STAT_DROPPED;
                  drop_seen = 1'b1;
               end else begin
                  store_l[wr_idx] = it.left_in;
                  store_r[wr_idx] = it.right_in;
                  wr_idx++;
                  held++;
                  total_in++;
               end
               if (it.last_of_call) begin
                  if (drop_seen) total_over++;
                  drop_seen = 1'b0;
                  if (cur_mode == MODE_PREBUFFER && held >= prebuf_level)
                     cur_mode = MODE_ACTIVE;
               end
            end
         end
         CMD_PULL: begin
            if (cur_mode != MODE_ACTIVE && cur_mode != MODE_DRAINING) begin
               st = STAT_REFUSED;
               if (it.last_of_call) short_seen = 1'b0;
            end else begin
               if (!short_seen && held != 0) begin
                  cl = store_l[rd_idx];
                  cr = store_r[rd_idx];
                  rd_idx++;
                  held--;
                  // int division truncates toward zero
                  ml = (int'(prev_l) + int'(cl)) / 2;
                  mr = (int'(prev_r) + int'(cr)) / 2;
                  prev_l = cl;
                  prev_r = cr;
                  audio = 1'b1;
               end else begin
                  short_seen = 1'b1;
               end
               total_out += 2;
               if (it.last_of_call) begin
                  if (short_seen) begin
                     if (cur_mode == MODE_DRAINING) cur_mode = MODE_INACTIVE;
                     else total_under++;
                  end
                  short_seen = 1'b0;
               end
            end
         end
         CMD_DRAIN: begin
            if (cur_mode == MODE_ACTIVE || cur_mode == MODE_PREBUFFER)
               cur_mode = MODE_DRAINING;
            else
               st = STAT_REFUSED;
         end
         CMD_START: begin
            if (cur_mode != MODE_INACTIVE || store_live) begin
               st = STAT_REFUSED;
            end else begin
               store_live  = 1'b1;
               rd_idx      = '0;
               wr_idx      = '0;
               held        = '0;
               prev_l      = '0;
               prev_r      = '0;
               total_under = '0;
               total_over  = '0;
               total_in    = '0;
               total_out   = '0;
               short_seen  = 1'b0;
               drop_seen   = 1'b0;
               cur_mode    = MODE_PREBUFFER;
            end
         end
         CMD_STOP: begin
            cur_mode   = MODE_INACTIVE;
            store_live = 1'b0;
            rd_idx     = '0;
            wr_idx     = '0;
            held       = '0;
            short_seen = 1'b0;
            drop_seen  = 1'b0;
         end
         default: st = STAT_REFUSED;
      endcase
      if (it.command == CMD_PULL && st == STAT_OK) begin
         owed_frames.push_back(make_rsp(ml[15:0], mr[15:0], 1'b0, st, audio));
         owed_frames.push_back(make_rsp(cl, cr, 1'b1, st, audio));
      end else begin
         owed_frames.push_back(make_rsp('0, '0, 1'b1, st, 1'b0));
      end
   endfunction

   function automatic req_type mk_item(input logic [2:0] cmd, input logic eol);
      req_type it;
      it.command      = cmd;
      it.left_in      = SAMPLE_W'($urandom());
      it.right_in     = SAMPLE_W'($urandom());
      it.last_of_call = eol;
      return it;
   endfunction

   function automatic step_row row(input logic [2:0] cmd,
                                   input logic signed [SAMPLE_W-1:0] l,
                                   input logic signed [SAMPLE_W-1:0] r,
                                   input logic eol, input bit typed,
                                   input status_type st, input mode_type md);
      step_row s;
      s.item.command      = cmd;
      s.item.left_in      = l;
      s.item.right_in     = r;
      s.item.last_of_call = eol;
      s.typed             = typed;
      s.want_status       = st;
      s.want_mode         = md;
      return s;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endfunction

   function automatic void redraw_idling();
      if ($urandom_range(0, 29) == 0) begin
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
      end
   endfunction

   // Called just after a rising edge; returns at the edge of the transfer.
   task automatic send_item(input req_type it);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_fifo(it);
   endtask

   task automatic run_call(input logic [2:0] cmd, input int len);
      for (int i = 0; i < len; i++) begin
         send_item(mk_item(cmd, i == len - 1));
         effective++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (owed_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_prebuffer(input logic [CFG_W-1:0] level);
      csr_write_enable <= 1'b1;
      csr_write_data   <= level;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      prebuf_level = level;
   endtask

   // result side: random stall before each transfer
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result expected none, got %h", $time, rsp_data);
         end else begin
            want = owed_frames.pop_front();
            compare_field("left_out", 32'(want.left_out), 32'(rsp_data.left_out));
            compare_field("right_out", 32'(want.right_out), 32'(rsp_data.right_out));
            compare_field("last", 32'(want.last), 32'(rsp_data.last));
            compare_field("status", 32'(want.status), 32'(rsp_data.status));
            compare_field("audio_valid", 32'(want.audio_valid),
                          32'(rsp_data.audio_valid));
            compare_field("mode", 32'(want.mode), 32'(rsp_data.mode));
            compare_field("fill_level", 32'(want.fill_level), 32'(rsp_data.fill_level));
            compare_field("underrun_count", want.underrun_count, rsp_data.underrun_count);
            compare_field("overflow_count", want.overflow_count, rsp_data.overflow_count);
            compare_field("frames_in", want.frames_in, rsp_data.frames_in);
            compare_field("frames_out", want.frames_out, rsp_data.frames_out);
         end
      end
   end

   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      step_row directed[$];
      logic [CFG_W-1:0] phase_level[NUM_PHASES];
      bit paused;
      int pick;

      rd_idx       = '0;
      wr_idx       = '0;
      held         = '0;
      cur_mode     = MODE_INACTIVE;
      store_live   = 1'b0;
      prev_l       = '0;
      prev_r       = '0;
      total_under  = '0;
      total_over   = '0;
      total_in     = '0;
      total_out    = '0;
      short_seen   = 1'b0;
      drop_seen    = 1'b0;
      prebuf_level = PREBUF_RESET;

      directed = '{
         // everything but stop refused before the first start; then a second start and an early pull
         row(CMD_PUSH, 16'sh7fff, 16'sh8000, 1'b1, 1, STAT_REFUSED, MODE_INACTIVE),
         row(CMD_PULL, 16'sh0000, 16'sh0000, 1'b1, 1, STAT_REFUSED, MODE_INACTIVE),
         row(CMD_DRAIN, 16'sh0000, 16'sh0000, 1'b0, 1, STAT_REFUSED, MODE_INACTIVE),
         row(CMD_SPARE, 16'shffff, 16'shffff, 1'b1, 1, STAT_REFUSED, MODE_INACTIVE),
         row(CMD_STOP, 16'sh0000, 16'sh0000, 1'b0, 1, STAT_OK, MODE_INACTIVE),
         row(CMD_START, 16'sh0000, 16'sh0000, 1'b0, 1, STAT_OK, MODE_PREBUFFER),
         row(CMD_START, 16'sh0000, 16'sh0000, 1'b0, 1, STAT_REFUSED, MODE_PREBUFFER),
         row(CMD_PULL, 16'sh0000, 16'sh0000, 1'b0, 1, STAT_REFUSED, MODE_PREBUFFER),
         // extremes, then midpoints that need truncation toward zero
         row(CMD_PUSH, 16'sh7fff, 16'sh8000, 1'b0, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PUSH, 16'sh8000, 16'sh7fff, 1'b1, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PUSH, -16'sd3, 16'sd3, 1'b1, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PULL, 16'sh0000, 16'sh0000, 1'b0, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PULL, 16'sh0000, 16'sh0000, 1'b0, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PULL, 16'sh0000, 16'sh0000, 1'b1, 0, STAT_OK, MODE_INACTIVE),
         // empty pull stays silent for the rest of the call, then underrun
         row(CMD_PULL, 16'sh0000, 16'sh0000, 1'b0, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PUSH, 16'sd100, -16'sd100, 1'b1, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PULL, 16'sh0000, 16'sh0000, 1'b1, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PULL, 16'sh0000, 16'sh0000, 1'b1, 0, STAT_OK, MODE_INACTIVE),
         // drain: push still taken, shortfall ends it
         row(CMD_DRAIN, 16'sh0000, 16'sh0000, 1'b0, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PUSH, 16'sd5, 16'sd5, 1'b1, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PULL, 16'sh0000, 16'sh0000, 1'b0, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PULL, 16'sh0000, 16'sh0000, 1'b1, 0, STAT_OK, MODE_INACTIVE),
         // store still held after drain: start needs a stop first
         row(CMD_START, 16'sh0000, 16'sh0000, 1'b0, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_STOP, 16'sh0000, 16'sh0000, 1'b0, 0, STAT_OK, MODE_INACTIVE),
         row(CMD_PUSH, 16'sh1234, 16'sh4321, 1'b1, 0, STAT_OK, MODE_INACTIVE)
      };

      phase_level[0] = 9'd256;
      phase_level[1] = 9'd1;
      phase_level[2] = 9'd0;
      phase_level[3] = 9'd511;
      phase_level[4] = 9'($urandom_range(1, 256));
      phase_level[5] = 9'($urandom_range(1, 16));
      phase_level[6] = PREBUF_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_prebuffer(9'd2);

      foreach (directed[i]) begin
         send_item(directed[i].item);
         if (directed[i].typed)
            owed_frames[$] = plain_rsp(directed[i].want_status, directed[i].want_mode);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         write_prebuffer(phase_level[p]);
         effective = 0;
         paused = 1'b0;
         run_call(CMD_STOP, 1);
         run_call(CMD_START, 1);
         while (effective < ITEMS_PER_PHASE) begin
            redraw_idling();
            if (!paused && effective >= ITEMS_PER_PHASE / 2) begin
               // sender holds off until the block has nothing left to deliver
               wait_drained();
               paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               send_item(mk_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
               effective++;
            end else if (pick < 14) begin
               run_call(CMD_STOP, 1);
               run_call(CMD_START, 1);
            end else if (pick < 18) begin
               run_call(CMD_DRAIN, 1);
            end else if (pick < 60) begin
               run_call(CMD_PUSH, ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90)
                                                               : $urandom_range(1, 16));
            end else begin
               run_call(CMD_PULL, $urandom_range(1, 12));
            end
         end
      end

      req_valid <= 1'b0;
      while (owed_frames.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && owed_frames.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/afu_pkg.sv
src/afu_ram.sv
src/afu_out.sv
src/afu_ctl.sv
src/audio_staging_fifo_upsampler_top.sv
sim/tb_audio_staging_fifo_upsampler_top.sv
